FILE: hdl/ucc_pkg.sv
// Shared types and constants for the epoch-seconds / calendar converter.
// No dependencies; used by ucc_month_find and unix_seconds_calendar_convert_top.

package ucc_pkg;

   typedef enum logic {
      KIND_SPLIT = 1'b0,   // seconds -> calendar
      KIND_JOIN  = 1'b1    // calendar -> seconds
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] in_seconds;
      logic [11:0] in_year;
      logic [3:0]  in_month;
      logic [4:0]  in_day;
      logic [4:0]  in_hour;
      logic [5:0]  in_minute;
      logic [5:0]  in_second;
   } req_type;

   typedef struct packed {
      logic [31:0] out_seconds;
      logic [11:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [4:0]  out_hour;
      logic [5:0]  out_minute;
      logic [5:0]  out_second;
      logic        valid_res;
   } rsp_type;

   localparam int MonthsPerCycle = 48;

   localparam logic [11:0] FirstYear = 12'd1970;
   localparam logic [11:0] LastYear  = 12'd2099;

   localparam logic [16:0] SecPerDay   = 17'd86400;
   localparam logic [10:0] DaysPerCycle = 11'd1461;
   localparam logic [8:0]  DaysPerYear = 9'd365;

   // reciprocals for constant division, q = (x * M) >> K
   localparam logic [25:0] RecipDay    = 26'd50903317;  // /675 after >>7, K=35
   localparam logic [16:0] RecipCycle  = 17'd91868;     // /1461, K=27
   localparam logic [15:0] RecipMin    = 16'd34953;     // /15 after >>2, K=19
   localparam logic [13:0] RecipHour   = 14'd9321;      // /225 after >>4, K=21

   // first day of each month within the four-year cycle (1970 = year 0, 1972 leap)
   localparam logic [10:0] MonthStart [MonthsPerCycle] = '{
      11'd0,    11'd31,   11'd59,   11'd90,   11'd120,  11'd151,
      11'd181,  11'd212,  11'd243,  11'd273,  11'd304,  11'd334,
      11'd365,  11'd396,  11'd424,  11'd455,  11'd485,  11'd516,
      11'd546,  11'd577,  11'd608,  11'd638,  11'd669,  11'd699,
      11'd730,  11'd761,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065,
      11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430
   };

   // day of year (1-based) of the first of a month, non-leap year
   function automatic logic [8:0] first_doy(input logic [3:0] month);
      logic [8:0] doy;
      unique case (month)
         4'd1:    doy = 9'd1;
         4'd2:    doy = 9'd32;
         4'd3:    doy = 9'd60;
         4'd4:    doy = 9'd91;
         4'd5:    doy = 9'd121;
         4'd6:    doy = 9'd152;
         4'd7:    doy = 9'd182;
         4'd8:    doy = 9'd213;
         4'd9:    doy = 9'd244;
         4'd10:   doy = 9'd274;
         4'd11:   doy = 9'd305;
         4'd12:   doy = 9'd335;
         default: doy = 9'd0;
      endcase
      return doy;
   endfunction

endpackage

FILE: hdl/ucc_month_find.sv
// Month lookup within the four-year cycle: day of cycle -> month index 0..47.
// Depends on ucc_pkg (MonthStart table).

module ucc_month_find import ucc_pkg::*; (
   input  logic [10:0] cycle_day,
   output logic [5:0]  month_index
);

   // starts are ascending, so the last start not above the day wins
   always_comb begin
      month_index = '0;
      for (int k = 1; k < MonthsPerCycle; k++) begin
         if (cycle_day >= MonthStart[k]) begin
            month_index = 6'(k);
         end
      end
   end

endmodule

FILE: hdl/unix_seconds_calendar_convert_top.sv
// Epoch-seconds <-> calendar converter, top level.
// Depends on ucc_pkg and ucc_month_find.
//
// Usage:
//   req_* carries one conversion per beat. kind KIND_SPLIT turns in_seconds
//   into year/month/day/hour/minute/second; kind KIND_JOIN turns the
//   calendar fields into out_seconds, with valid_res low (and all fields
//   zero) when the year is outside 1970..2099 or the month outside 1..12.
//   Fields that a kind does not produce come back zero.
//   rsp_* returns exactly one beat per request, in order.
// Timing:
//   Five-register pipeline (input register, three work stages, result
//   register). One beat per cycle sustained while rsp_stall is low; the
//   constant-reciprocal multiplies sit in the first three logic stages,
//   with the month compare bank in the third.
// Stall:
//   Each stage advances when it is empty or the next one advances, so
//   bubbles are squeezed out; with rsp_stall held high the pipe fills and
//   req_stall rises once all five registers hold beats.
// Reset:
//   Synchronous reset empties the pipeline; the data registers are not reset.

module unix_seconds_calendar_convert_top import ucc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        secs;
      logic [15:0]        days;
      logic [16:0]        cal_days;   // day count + 2, before the offset
      logic signed [18:0] cal_tod;    // time of day minus two days
      logic               cal_ok;
   } st1_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] days;
      logic [5:0]  cycle;
      logic [16:0] rem;
      logic [31:0] secs_out;
      logic        cal_ok;
   } st2_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  cycle;
      logic [10:0] cday;
      logic [5:0]  midx;
      logic [16:0] rem;
      logic [10:0] mins;
      logic [4:0]  hour;
      logic [31:0] secs_out;
      logic        cal_ok;
   } st3_type;

   localparam logic signed [18:0] TwoDays = 19'sd172800;

   req_type st0_ff;
   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   st3_type st3_ff, st3_in;
   rsp_type rsp_ff, rsp_in;

   logic v0_ff, v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic en0, en1, en2, en3, en4;

   // ---------------- flow control ----------------
   assign en4 = !rsp_valid_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en0 = !v0_ff || en1;

   assign req_stall = !en0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en0) v0_ff        <= req_valid;
         if (en1) v1_ff        <= v0_ff;
         if (en2) v2_ff        <= v1_ff;
         if (en3) v3_ff        <= v2_ff;
         if (en4) rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) st0_ff <= req_data;
      if (en1) st1_ff <= st1_in;
      if (en2) st2_ff <= st2_in;
      if (en3) st3_ff <= st3_in;
      if (en4) rsp_ff <= rsp_in;
   end

   // ---------------- stage 1: days of epoch / calendar day count ----------------
   logic [50:0] day_prod;
   logic [7:0]  yr_off;
   logic [8:0]  yr_off1;
   logic        leap_adj;
   logic [16:0] tod_sum;

   always_comb begin
      day_prod = 51'(st0_ff.in_seconds[31:7]) * 51'(RecipDay);
      yr_off   = 8'(st0_ff.in_year - FirstYear);
      yr_off1  = {1'b0, yr_off} + 9'd1;
      leap_adj = (st0_ff.in_year[1:0] == 2'b00) && (st0_ff.in_month >= 4'd3);
      tod_sum  = 17'(st0_ff.in_hour * 17'd3600) + 17'(st0_ff.in_minute * 17'd60)
               + 17'(st0_ff.in_second);

      st1_in.kind     = st0_ff.kind;
      st1_in.secs     = st0_ff.in_seconds;
      st1_in.days     = day_prod[50:35];
      st1_in.cal_days = 17'({9'd0, yr_off} * 17'(DaysPerYear))
                      + 17'(yr_off1[8:2])
                      + 17'(first_doy(st0_ff.in_month))
                      + 17'(st0_ff.in_day)
                      + 17'(leap_adj);
      st1_in.cal_tod  = $signed({2'b00, tod_sum}) - TwoDays;
      st1_in.cal_ok   = (st0_ff.in_year >= FirstYear) && (st0_ff.in_year <= LastYear)
                     && (st0_ff.in_month >= 4'd1) && (st0_ff.in_month <= 4'd12);
   end

   // ---------------- stage 2: remainder, cycle count, joined seconds ----------------
   logic [32:0]        day_secs;
   logic [32:0]        cyc_prod;
   logic [33:0]        cal_prod;
   logic signed [35:0] cal_total;

   always_comb begin
      day_secs  = 33'(st1_ff.days) * 33'(SecPerDay);
      cyc_prod  = 33'(st1_ff.days) * 33'(RecipCycle);
      cal_prod  = 34'(st1_ff.cal_days) * 34'(SecPerDay);
      cal_total = $signed({2'b00, cal_prod}) + 36'(st1_ff.cal_tod);

      st2_in.kind  = st1_ff.kind;
      st2_in.days  = st1_ff.days;
      st2_in.cycle = cyc_prod[32:27];
      st2_in.rem   = 17'({1'b0, st1_ff.secs} - day_secs);
      st2_in.cal_ok = st1_ff.cal_ok;
      // clamp to the 32-bit range: before the epoch reads as zero, past it as all ones
      priority if (cal_total[35]) begin
         st2_in.secs_out = '0;
      end else if (|cal_total[34:32]) begin
         st2_in.secs_out = '1;
      end else begin
         st2_in.secs_out = cal_total[31:0];
      end
   end

   // ---------------- stage 3: day of cycle, month, minutes, hours ----------------
   logic [16:0] cyc_days;
   logic [10:0] cday;
   logic [5:0]  midx;
   logic [30:0] min_prod;
   logic [26:0] hour_prod;

   assign cyc_days = 17'(st2_ff.cycle) * 17'(DaysPerCycle);
   assign cday     = 11'({1'b0, st2_ff.days} - cyc_days);

   ucc_month_find u_month_find (
      .cycle_day   (cday),
      .month_index (midx)
   );

   always_comb begin
      min_prod  = 31'(st2_ff.rem[16:2]) * 31'(RecipMin);
      hour_prod = 27'(st2_ff.rem[16:4]) * 27'(RecipHour);

      st3_in.kind     = st2_ff.kind;
      st3_in.cycle    = st2_ff.cycle;
      st3_in.cday     = cday;
      st3_in.midx     = midx;
      st3_in.rem      = st2_ff.rem;
      st3_in.mins     = min_prod[29:19];
      st3_in.hour     = hour_prod[25:21];
      st3_in.secs_out = st2_ff.secs_out;
      st3_in.cal_ok   = st2_ff.cal_ok;
   end

   // ---------------- stage 4: field assembly ----------------
   logic [1:0]  yr_in_cycle;
   logic [5:0]  mon_base;
   logic [10:0] hour_mins;
   logic [16:0] min_secs;

   always_comb begin
      priority if (st3_ff.midx >= 6'd36) begin
         yr_in_cycle = 2'd3;
      end else if (st3_ff.midx >= 6'd24) begin
         yr_in_cycle = 2'd2;
      end else if (st3_ff.midx >= 6'd12) begin
         yr_in_cycle = 2'd1;
      end else begin
         yr_in_cycle = 2'd0;
      end
      mon_base  = 6'(yr_in_cycle * 6'd12);
      hour_mins = 11'(st3_ff.hour) * 11'd60;
      min_secs  = 17'(st3_ff.mins) * 17'd60;

      rsp_in = '0;
      unique case (st3_ff.kind)
         KIND_SPLIT: begin
            rsp_in.out_year   = FirstYear + 12'({st3_ff.cycle, 2'b00}) + 12'(yr_in_cycle);
            rsp_in.out_month  = 4'(st3_ff.midx - mon_base + 6'd1);
            rsp_in.out_day    = 5'(st3_ff.cday - MonthStart[st3_ff.midx] + 11'd1);
            rsp_in.out_hour   = st3_ff.hour;
            rsp_in.out_minute = 6'(st3_ff.mins - hour_mins);
            rsp_in.out_second = 6'(st3_ff.rem - min_secs);
            rsp_in.valid_res  = 1'b1;
         end
         KIND_JOIN: begin
            if (st3_ff.cal_ok) begin
               rsp_in.out_seconds = st3_ff.secs_out;
               rsp_in.valid_res   = 1'b1;
            end
         end
         default: rsp_in = '0;
      endcase
   end

   // ---------------- checks ----------------
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data == '0)
      else $error("invalid result carries nonzero fields");

   a_split_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_year != '0 |->
         rsp_data.out_seconds == '0 && rsp_data.out_month >= 4'd1
         && rsp_data.out_month <= 4'd12 && rsp_data.out_day >= 5'd1
         && rsp_data.out_hour <= 5'd23 && rsp_data.out_minute <= 6'd59
         && rsp_data.out_second <= 6'd59)
      else $error("calendar fields out of range");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

endmodule
